>>> rtl/i2c_mbs_pkg.sv
// Shared types and codes for the I2C master bit sequencer.
package i2c_mbs_pkg;

    localparam int unsigned BYTE_BITS = 8;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_HIGH = 5'd1,
        PH_ST_FALL = 5'd2,
        PH_W_LOW   = 5'd3,
        PH_W_SET   = 5'd4,
        PH_W_HIGH  = 5'd5,
        PH_WA_LOW  = 5'd6,
        PH_WA_REL  = 5'd7,
        PH_WA_HIGH = 5'd8,
        PH_WA_SAMP = 5'd9,
        PH_R_LOW   = 5'd10,
        PH_R_HIGH  = 5'd11,
        PH_R_SAMP  = 5'd12,
        PH_RA_LOW  = 5'd13,
        PH_RA_SET  = 5'd14,
        PH_RA_HIGH = 5'd15,
        PH_P_LOW   = 5'd16,
        PH_P_SDA   = 5'd17,
        PH_P_HIGH  = 5'd18,
        PH_P_REL   = 5'd19
    } t_phase;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ADDR_NACK = 2'd1,
        ERR_DATA_NACK = 2'd2
    } t_err;

endpackage

>>> rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one pin phase per accepted input word.
// Each result word is registered at the edge that accepts its input word.
// Throughput: one word per cycle while the input is not stalled; the phase state machine and the result
// register are both updated at the edge that accepts the input word.
// The input side stalls only while a result word is waiting and stalled.
// Synchronous active-low reset puts the bus idle with SCL and SDA driven high.
module i2c_master_bit_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_target_address,
    input  logic       i_read_direction,
    input  logic [7:0] i_tx_byte,
    input  logic       i_last_read,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_released,
    output logic       o_busy_res,
    output logic       o_cmd_done,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_received,
    output logic [1:0] o_error_code
);

    i2c_mbs_pkg::t_phase r_phase, n_phase, l_phase;
    i2c_mbs_pkg::t_kind  r_cmd, l_cmd;
    logic [3:0] r_count, l_count, n_count, cnt_inc;
    logic [7:0] r_shift, l_shift, n_shift;
    logic       r_nack, l_nack;
    logic [1:0] r_err, l_err, n_err;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_float, n_float;
    logic       r_ack, n_ack;
    logic [7:0] r_rx, n_rx;
    logic       r_done, n_done;
    logic       r_out_valid;
    logic       in_acc;

    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign cnt_inc = l_count + 4'd1;

    always_comb begin
        l_phase = r_phase;
        l_cmd   = r_cmd;
        l_count = r_count;
        l_shift = r_shift;
        l_nack  = r_nack;
        l_err   = r_err;
        if (r_phase == i2c_mbs_pkg::PH_IDLE && i_cmd_valid) begin
            l_cmd   = i2c_mbs_pkg::t_kind'(i_kind);
            l_count = 4'd0;
            unique case (i2c_mbs_pkg::t_kind'(i_kind))
                i2c_mbs_pkg::KIND_START: begin
                    l_err   = i2c_mbs_pkg::ERR_NONE;
                    l_shift = {i_target_address, i_read_direction};
                    l_phase = i2c_mbs_pkg::PH_ST_HIGH;
                end
                i2c_mbs_pkg::KIND_WRITE: begin
                    l_shift = i_tx_byte;
                    l_phase = i2c_mbs_pkg::PH_W_LOW;
                end
                i2c_mbs_pkg::KIND_READ: begin
                    l_shift = 8'd0;
                    l_nack  = i_last_read;
                    l_phase = i2c_mbs_pkg::PH_R_LOW;
                end
                default: begin
                    l_phase = i2c_mbs_pkg::PH_P_LOW;
                end
            endcase
        end
    end

    always_comb begin
        unique case (l_phase)
            i2c_mbs_pkg::PH_IDLE:    n_phase = i2c_mbs_pkg::PH_IDLE;
            i2c_mbs_pkg::PH_ST_HIGH: n_phase = i2c_mbs_pkg::PH_ST_FALL;
            i2c_mbs_pkg::PH_ST_FALL: n_phase = i2c_mbs_pkg::PH_W_LOW;
            i2c_mbs_pkg::PH_W_LOW:   n_phase = i2c_mbs_pkg::PH_W_SET;
            i2c_mbs_pkg::PH_W_SET:   n_phase = i2c_mbs_pkg::PH_W_HIGH;
            i2c_mbs_pkg::PH_W_HIGH:  n_phase = (cnt_inc >= 4'(i2c_mbs_pkg::BYTE_BITS)) ?
                                               i2c_mbs_pkg::PH_WA_LOW : i2c_mbs_pkg::PH_W_LOW;
            i2c_mbs_pkg::PH_WA_LOW:  n_phase = i2c_mbs_pkg::PH_WA_REL;
            i2c_mbs_pkg::PH_WA_REL:  n_phase = i2c_mbs_pkg::PH_WA_HIGH;
            i2c_mbs_pkg::PH_WA_HIGH: n_phase = i2c_mbs_pkg::PH_WA_SAMP;
            i2c_mbs_pkg::PH_WA_SAMP: n_phase = i2c_mbs_pkg::PH_IDLE;
            i2c_mbs_pkg::PH_R_LOW:   n_phase = i2c_mbs_pkg::PH_R_HIGH;
            i2c_mbs_pkg::PH_R_HIGH:  n_phase = i2c_mbs_pkg::PH_R_SAMP;
            i2c_mbs_pkg::PH_R_SAMP:  n_phase = (cnt_inc >= 4'(i2c_mbs_pkg::BYTE_BITS)) ?
                                               i2c_mbs_pkg::PH_RA_LOW : i2c_mbs_pkg::PH_R_LOW;
            i2c_mbs_pkg::PH_RA_LOW:  n_phase = i2c_mbs_pkg::PH_RA_SET;
            i2c_mbs_pkg::PH_RA_SET:  n_phase = i2c_mbs_pkg::PH_RA_HIGH;
            i2c_mbs_pkg::PH_RA_HIGH: n_phase = i2c_mbs_pkg::PH_IDLE;
            i2c_mbs_pkg::PH_P_LOW:   n_phase = i2c_mbs_pkg::PH_P_SDA;
            i2c_mbs_pkg::PH_P_SDA:   n_phase = i2c_mbs_pkg::PH_P_HIGH;
            i2c_mbs_pkg::PH_P_HIGH:  n_phase = i2c_mbs_pkg::PH_P_REL;
            i2c_mbs_pkg::PH_P_REL:   n_phase = i2c_mbs_pkg::PH_IDLE;
            default:                 n_phase = i2c_mbs_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        n_count = l_count;
        n_shift = l_shift;
        n_err   = l_err;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_float = r_float;
        n_ack   = r_ack;
        n_rx    = r_rx;
        n_done  = 1'b0;
        unique case (l_phase) inside
            i2c_mbs_pkg::PH_ST_HIGH: begin
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_float = 1'b0;
            end
            i2c_mbs_pkg::PH_ST_FALL: begin
                n_sda   = 1'b0;
                n_float = 1'b0;
            end
            i2c_mbs_pkg::PH_W_LOW, i2c_mbs_pkg::PH_WA_LOW, i2c_mbs_pkg::PH_RA_LOW,
            i2c_mbs_pkg::PH_P_LOW: begin
                n_scl = 1'b0;
            end
            i2c_mbs_pkg::PH_W_SET: begin
                n_sda   = l_shift[7];
                n_float = 1'b0;
            end
            i2c_mbs_pkg::PH_W_HIGH: begin
                n_scl   = 1'b1;
                n_shift = {l_shift[6:0], 1'b0};
                n_count = cnt_inc;
            end
            i2c_mbs_pkg::PH_WA_REL: begin
                n_float = 1'b1;
            end
            i2c_mbs_pkg::PH_WA_HIGH, i2c_mbs_pkg::PH_R_HIGH, i2c_mbs_pkg::PH_P_HIGH: begin
                n_scl = 1'b1;
            end
            i2c_mbs_pkg::PH_WA_SAMP: begin
                n_ack  = ~i_sda_in;
                n_done = 1'b1;
                if (i_sda_in) begin
                    n_err = (l_cmd == i2c_mbs_pkg::KIND_START) ?
                            i2c_mbs_pkg::ERR_ADDR_NACK : i2c_mbs_pkg::ERR_DATA_NACK;
                end
            end
            i2c_mbs_pkg::PH_R_LOW: begin
                n_scl   = 1'b0;
                n_float = 1'b1;
            end
            i2c_mbs_pkg::PH_R_SAMP: begin
                n_shift = {l_shift[6:0], i_sda_in};
                n_count = cnt_inc;
            end
            i2c_mbs_pkg::PH_RA_SET: begin
                n_sda   = l_nack;
                n_float = 1'b0;
            end
            i2c_mbs_pkg::PH_RA_HIGH: begin
                n_scl  = 1'b1;
                n_rx   = l_shift;
                n_done = 1'b1;
            end
            i2c_mbs_pkg::PH_P_SDA: begin
                n_sda   = 1'b0;
                n_float = 1'b0;
            end
            i2c_mbs_pkg::PH_P_REL: begin
                n_sda   = 1'b1;
                n_float = 1'b0;
                n_done  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2c_mbs_pkg::PH_IDLE;
            r_cmd       <= i2c_mbs_pkg::KIND_START;
            r_count     <= 4'd0;
            r_shift     <= 8'd0;
            r_nack      <= 1'b0;
            r_err       <= i2c_mbs_pkg::ERR_NONE;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_float     <= 1'b0;
            r_ack       <= 1'b0;
            r_rx        <= 8'd0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_acc | (r_out_valid & i_stall);
            if (in_acc) begin
                r_phase <= n_phase;
                r_cmd   <= l_cmd;
                r_count <= n_count;
                r_shift <= n_shift;
                r_nack  <= l_nack;
                r_err   <= n_err;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_float <= n_float;
                r_ack   <= n_ack;
                r_rx    <= n_rx;
                r_done  <= n_done;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_scl_level    = r_scl;
    assign o_sda_level    = r_sda;
    assign o_sda_released = r_float;
    assign o_busy_res     = (r_phase != i2c_mbs_pkg::PH_IDLE);
    assign o_cmd_done     = r_done;
    assign o_rx_byte      = r_rx;
    assign o_ack_received = r_ack;
    assign o_error_code   = r_err;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_done |-> !o_busy_res)
        else $error("command done reported while still busy");

    a_err_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_error_code != 2'd3)
        else $error("illegal error code");

    a_cmd_starts_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd_valid && r_phase == i2c_mbs_pkg::PH_IDLE) |=> o_busy_res)
        else $error("accepted command did not make the sequencer busy");

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_phase))
        else $error("phase moved without an accepted word");
`endif

endmodule
